/* design/yuv_to_rgba_pixel_converter_core_macros.svh */
// Assertion helpers for the pixel converter.
`ifndef YUV_TO_RGBA_PIXEL_CONVERTER_CORE_MACROS_SVH
`define YUV_TO_RGBA_PIXEL_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define YRC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Delayed implication across the pipeline, masked during reset.
`define YRC_ASSERT_LAT3(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error(msg);

`endif

/* design/yuvrgb_pkg.sv */
package yuvrgb_pkg;

	// Register indexes on the config port
	typedef enum logic [2:0] {
		REG_MATRIX_CODE  = 3'd0,
		REG_FULL_RANGE   = 3'd1,
		REG_BIT_DEPTH    = 3'd2,
		REG_MONOCHROME   = 3'd3,
		REG_ALPHA_ENABLE = 3'd4
	} reg_idx_t;

	// Matrix codes that the coefficient select recognises
	localparam logic [7:0] MC_IDENTITY    = 8'd0;
	localparam logic [7:0] MC_BT709       = 8'd1;
	localparam logic [7:0] MC_BT2020_NCL  = 8'd9;
	localparam logic [7:0] MC_BT2020_CL   = 8'd10;

	localparam int PROD_W = 19;
	localparam int SUM_W  = 20;

	localparam logic [8:0] CY_FULL    = 9'd256;
	localparam logic [8:0] CY_LIMITED = 9'd298;
	localparam logic [4:0] YSUB_LIM   = 5'd16;
	localparam logic [7:0] OPAQUE     = 8'd255;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(128);

	typedef struct packed {
		logic [7:0] matrix_code;
		logic       full_range;
		logic [3:0] bit_depth;
		logic       monochrome;
		logic       alpha_enable;
	} cfg_t;

	typedef struct packed {
		logic       ident;     // identity mode: Y->G, Cb->B, Cr->R
		logic       mono;      // chroma forced to zero
		logic [8:0] cy;
		logic [4:0] ysub;
		logic [9:0] crv;
		logic [6:0] cgu;
		logic [7:0] cgv;
		logic [9:0] cbu;
	} coeff_t;

	typedef struct packed {
		logic [7:0] y8;
		logic [7:0] u8;
		logic [7:0] v8;
		logic [7:0] alpha;
	} s1_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] base_r;
		logic signed [PROD_W-1:0] base_g;
		logic signed [PROD_W-1:0] base_b;
		logic signed [PROD_W-1:0] crv_e;
		logic signed [PROD_W-1:0] cgu_d;
		logic signed [PROD_W-1:0] cgv_e;
		logic signed [PROD_W-1:0] cbu_d;
		logic [7:0]               alpha;
	} s2_t;

endpackage

/* design/yuvrgb_cfg.sv */
module yuvrgb_cfg
	import yuvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg,
	output coeff_t     coeff
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix_code  <= MC_BT709;
			cfg_q.full_range   <= 1'b0;
			cfg_q.bit_depth    <= 4'd8;
			cfg_q.monochrome   <= 1'b0;
			cfg_q.alpha_enable <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MATRIX_CODE:  cfg_q.matrix_code  <= wr_data;
				REG_FULL_RANGE:   cfg_q.full_range   <= wr_data[0];
				REG_BIT_DEPTH:    cfg_q.bit_depth    <= wr_data[3:0];
				REG_MONOCHROME:   cfg_q.monochrome   <= wr_data[0];
				REG_ALPHA_ENABLE: cfg_q.alpha_enable <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	logic bt709, bt2020;

	always_comb begin
		bt709  = (cfg_q.matrix_code == MC_BT709);
		bt2020 = (cfg_q.matrix_code == MC_BT2020_NCL) || (cfg_q.matrix_code == MC_BT2020_CL);
		coeff.mono  = cfg_q.monochrome;
		coeff.ident = (cfg_q.matrix_code == MC_IDENTITY) && !cfg_q.monochrome;
		if (cfg_q.full_range) begin
			coeff.cy   = CY_FULL;
			coeff.ysub = 5'd0;
			priority if (bt709) begin
				coeff.crv = 10'd403; coeff.cgu = 7'd48; coeff.cgv = 8'd120; coeff.cbu = 10'd475;
			end else if (bt2020) begin
				coeff.crv = 10'd378; coeff.cgu = 7'd42; coeff.cgv = 8'd146; coeff.cbu = 10'd482;
			end else begin
				coeff.crv = 10'd359; coeff.cgu = 7'd88; coeff.cgv = 8'd183; coeff.cbu = 10'd454;
			end
		end else begin
			coeff.cy   = CY_LIMITED;
			coeff.ysub = YSUB_LIM;
			priority if (bt709) begin
				coeff.crv = 10'd459; coeff.cgu = 7'd55; coeff.cgv = 8'd136; coeff.cbu = 10'd541;
			end else if (bt2020) begin
				coeff.crv = 10'd430; coeff.cgu = 7'd48; coeff.cgv = 8'd167; coeff.cbu = 10'd548;
			end else begin
				coeff.crv = 10'd409; coeff.cgu = 7'd100; coeff.cgv = 8'd208; coeff.cbu = 10'd516;
			end
		end
	end

endmodule

/* design/yuvrgb_unpack.sv */
module yuvrgb_unpack
	import yuvrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [11:0] luma_sample,
	input  logic [11:0] cb_sample,
	input  logic [11:0] cr_sample,
	input  logic [7:0]  alpha_value,
	input  cfg_t        cfg,
	output logic        valid_s1,
	output s1_t         data_s1
);

	// Round to 8 bits, saturate at 255
	function automatic logic [7:0] reduce(input logic [11:0] raw, input logic [3:0] bd);
		logic [2:0]  sh;
		logic [12:0] acc;
		logic [12:0] red;
		if (bd > 4'd8) begin
			sh  = 3'(bd - 4'd8);
			acc = {1'b0, raw} + (13'd1 << (sh - 3'd1));
			red = acc >> sh;
		end else begin
			red = {1'b0, raw};
		end
		return (red > 13'd255) ? 8'hFF : red[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1.y8    <= reduce(luma_sample, cfg.bit_depth);
			data_s1.u8    <= reduce(cb_sample, cfg.bit_depth);
			data_s1.v8    <= reduce(cr_sample, cfg.bit_depth);
			data_s1.alpha <= cfg.alpha_enable ? alpha_value : OPAQUE;
		end
	end

endmodule

/* design/yuvrgb_mult.sv */
module yuvrgb_mult
	import yuvrgb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  s1_t    data_s1,
	input  coeff_t coeff,
	output logic   valid_s2,
	output s2_t    data_s2
);

	logic signed [PROD_W-1:0] cy_x, crv_x, cgu_x, cgv_x, cbu_x;
	logic signed [PROD_W-1:0] cr_x, cg_x, cb_x, d_x, e_x;
	logic [7:0] src_r, src_b;

	always_comb begin
		cy_x  = PROD_W'(coeff.cy);
		crv_x = PROD_W'(coeff.crv);
		cgu_x = PROD_W'(coeff.cgu);
		cgv_x = PROD_W'(coeff.cgv);
		cbu_x = PROD_W'(coeff.cbu);
		// identity mode feeds each channel its own sample through the luma path
		src_r = coeff.ident ? data_s1.v8 : data_s1.y8;
		src_b = coeff.ident ? data_s1.u8 : data_s1.y8;
		cr_x  = PROD_W'(src_r) - PROD_W'(coeff.ysub);
		cg_x  = PROD_W'(data_s1.y8) - PROD_W'(coeff.ysub);
		cb_x  = PROD_W'(src_b) - PROD_W'(coeff.ysub);
		// chroma offset from 128; zero in identity or mono
		if (coeff.ident || coeff.mono) begin
			d_x = '0;
			e_x = '0;
		end else begin
			d_x = PROD_W'(data_s1.u8) - PROD_W'(9'd128);
			e_x = PROD_W'(data_s1.v8) - PROD_W'(9'd128);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2.base_r <= cy_x * cr_x;
			data_s2.base_g <= cy_x * cg_x;
			data_s2.base_b <= cy_x * cb_x;
			data_s2.crv_e  <= crv_x * e_x;
			data_s2.cgu_d  <= cgu_x * d_x;
			data_s2.cgv_e  <= cgv_x * e_x;
			data_s2.cbu_d  <= cbu_x * d_x;
			data_s2.alpha  <= data_s1.alpha;
		end
	end

endmodule

/* design/yuvrgb_clip.sv */
module yuvrgb_clip
	import yuvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  s2_t        data_s2,
	output logic       valid_s3,
	output logic [7:0] red_s3,
	output logic [7:0] green_s3,
	output logic [7:0] blue_s3,
	output logic [7:0] alpha_s3
);

	// Floor shift by 8, clip to 0..255
	function automatic logic [7:0] clip8(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-9:0] hi;
		hi = s[SUM_W-1:8];
		if (s[SUM_W-1]) begin
			return 8'd0;
		end else if (hi > (SUM_W-8)'(255)) begin
			return 8'hFF;
		end else begin
			return hi[7:0];
		end
	endfunction

	logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

	always_comb begin
		sum_r = SUM_W'(data_s2.base_r) + SUM_W'(data_s2.crv_e) + ROUND_HALF;
		sum_g = SUM_W'(data_s2.base_g) - SUM_W'(data_s2.cgu_d) - SUM_W'(data_s2.cgv_e)
			+ ROUND_HALF;
		sum_b = SUM_W'(data_s2.base_b) + SUM_W'(data_s2.cbu_d) + ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			red_s3   <= clip8(sum_r);
			green_s3 <= clip8(sum_g);
			blue_s3  <= clip8(sum_b);
			alpha_s3 <= data_s2.alpha;
		end
	end

endmodule

/* design/yuv_to_rgba_pixel_converter_core.sv */
// Channel   Handshake               Payload
// pixel in  start / busy            luma_sample, cb_sample, cr_sample, alpha_value
// pixel out result_valid (strobe)   red, green, blue, alpha_out
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock once busy is low; nothing else holds the flow.
// Latency is set by the three register stages: reduce, multiply, sum and clip.
// busy is high during reset and for the first cycle out of reset, then low for good.
// The result strobe lasts one cycle and cannot be held off, so nothing stalls.
// cfg_ready is always high; registers take effect on the next word.
`include "yuv_to_rgba_pixel_converter_core_macros.svh"

module yuv_to_rgba_pixel_converter_core
	import yuvrgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// pixel in
	input  logic        start,
	output logic        busy,
	input  logic [11:0] luma_sample,
	input  logic [11:0] cb_sample,
	input  logic [11:0] cr_sample,
	input  logic [7:0]  alpha_value,
	// pixel out
	output logic        result_valid,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha_out,
	// config
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic   busy_q;
	logic   accept;
	cfg_t   cfg;
	coeff_t coeff;
	logic   valid_s1, valid_s2;
	s1_t    data_s1;
	s2_t    data_s2;

	// busy covers reset and the cycle after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	// register file plus coefficient select
	yuvrgb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.coeff    (coeff)
	);

	// stage 1: bit-depth reduction, alpha select
	yuvrgb_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (accept),
		.luma_sample (luma_sample),
		.cb_sample   (cb_sample),
		.cr_sample   (cr_sample),
		.alpha_value (alpha_value),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	// stage 2: seven coefficient products
	yuvrgb_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.coeff    (coeff),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// stage 3: accumulate, round, clip; drives the output ports directly
	yuvrgb_clip u_clip (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (result_valid),
		.red_s3   (red),
		.green_s3 (green),
		.blue_s3  (blue),
		.alpha_s3 (alpha_out)
	);

	// every taken word shows up as a result at the end of the pipeline
	`YRC_ASSERT_LAT3(a_latency, accept, result_valid, "pixel word lost in pipeline")
	// no result without a matching taken word
	`YRC_ASSERT_IMPLY(a_no_phantom, result_valid, $past(accept, 3), "spurious result word")
	// opaque alpha when the alpha plane is off
	`YRC_ASSERT_IMPLY(a_opaque, result_valid && !cfg.alpha_enable, alpha_out == OPAQUE,
		"alpha not opaque")

endmodule
